// File: hw/rtl/plist_pkg.sv
// Shared constants and types for the positional list block.
// Depends on nothing; imported by every module of the block.
package plist_pkg;

  // Field widths of the stream beats
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Default list capacity
  localparam int DEFAULT_CAPACITY = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READOUT = 2'd2;
  // Unused code; rejected as out of range
  localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // One result beat
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

endpackage

// File: hw/rtl/plist_ram.sv
// Entry store of the positional list: one write and one read port,
// read data registered. Depends on plist_pkg for the word width.
module plist_ram
  import plist_pkg::*;
#(
  parameter int DEPTH  = DEFAULT_CAPACITY,
  parameter int ADDR_W = $clog2(DEFAULT_CAPACITY)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; hold the data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/plist_out_reg.sv
// Output register of the positional list: holds one result beat until
// the sink takes it. Depends on plist_pkg for result_t.
module plist_out_reg
  import plist_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    ready,
  output logic    valid,
  output logic    free,
  output result_t res_q
);

  // Room for a new beat when empty or when the held beat leaves now
  assign free = !valid || ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

// File: hw/rtl/positional_list_insert_delete.sv
// Positional list: an ordered list of up to CAPACITY signed 32-bit values held in
// a single synchronous RAM. Commands are taken one at a time. An insert or a delete
// moves the tail one entry per cycle through the RAM's one read and one write port;
// a read-out gives one beat per cycle after the registered RAM read of the first
// entry, as fast as the sink takes them. Errors give a single beat at once. The list
// starts empty after reset with no clearing pass; the RAM contents are never read
// beyond the current length. A finished result waits in an output register, so
// the next command is taken while it is still pending.
module positional_list_insert_delete
  import plist_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  // Command beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [38:32] position, [39] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  // Result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] item_value
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast    // last
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_GET      = 3'd1;
  localparam logic [2:0] S_SHIFT    = 3'd2;
  localparam logic [2:0] S_PUT      = 3'd3;
  localparam logic [2:0] S_RD_ISSUE = 3'd4;
  localparam logic [2:0] S_RD_OUT   = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  // Control state
  logic [2:0]        state;
  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  rem;
  logic              pend;
  logic              first;
  logic              dir_up;
  // Payload registers
  logic [ADDR_W-1:0]  j;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  base;
  logic [VALUE_W-1:0] val;
  logic [VALUE_W-1:0] got;
  result_t            res;

  // Beat fields
  logic [CMD_W-1:0]   in_cmd;
  logic [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]   in_pos;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   len_x;
  logic               accept;

  // RAM and output register hookup
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;
  logic               out_load;
  logic               out_free;
  result_t            out_res;
  result_t            out_q;

  assign in_cmd   = s_tuser;
  assign in_value = s_tdata[31:0];
  assign in_pos   = s_tdata[38:32];
  assign pos_x    = CMP_W'(in_pos);
  assign len_x    = CMP_W'(length);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  plist_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plist_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (out_load),
    .res   (out_res),
    .ready (m_tready),
    .valid (m_tvalid),
    .free  (out_free),
    .res_q (out_q)
  );

  assign m_tdata = out_q.value;
  assign m_tuser = out_q.status;
  assign m_tlast = out_q.last;

  // Drive RAM ports and output loads from the current state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = j;
    out_load  = 1'b0;
    out_res   = res;
    case (state)
      S_GET: begin
        ram_re    = 1'b1;
        ram_raddr = base;
      end
      S_SHIFT: begin
        ram_re = (rem != '0);
        ram_we = pend;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = base;
        ram_wdata = val;
      end
      S_RD_ISSUE: begin
        ram_re = 1'b1;
      end
      S_RD_OUT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_res.value  = ram_rdata;
          out_res.status = ST_OK;
          out_res.last   = (rem == '0);
          ram_re         = (rem != '0);
        end
      end
      S_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: decode, move entries, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      length <= '0;
      rem    <= '0;
      pend   <= 1'b0;
      first  <= 1'b0;
      dir_up <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            val        <= in_value;
            base       <= ADDR_W'(in_pos - POS_W'(1));
            pend       <= 1'b0;
            res.value  <= '0;
            res.last   <= 1'b1;
            case (in_cmd)
              CMD_INSERT: begin
                if (in_pos == '0 || pos_x > len_x + CMP_W'(1)) begin
                  res.status <= ST_RANGE;
                  state      <= S_EMIT;
                end else if (length == LEN_W'(CAPACITY)) begin
                  res.status <= ST_FULL;
                  state      <= S_EMIT;
                end else begin
                  dir_up <= 1'b1;
                  first  <= 1'b0;
                  j      <= ADDR_W'(length - LEN_W'(1));
                  rem    <= LEN_W'(len_x - pos_x + CMP_W'(1));
                  state  <= S_SHIFT;
                end
              end
              CMD_DELETE: begin
                if (length == '0) begin
                  res.status <= ST_EMPTY;
                  state      <= S_EMIT;
                end else if (in_pos == '0 || pos_x > len_x) begin
                  res.status <= ST_RANGE;
                  state      <= S_EMIT;
                end else begin
                  dir_up <= 1'b0;
                  j      <= ADDR_W'(in_pos);
                  rem    <= LEN_W'(len_x - pos_x);
                  state  <= S_GET;
                end
              end
              CMD_READOUT: begin
                if (length == '0) begin
                  res.status <= ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  j     <= '0;
                  rem   <= length;
                  state <= S_RD_ISSUE;
                end
              end
              default: begin
                res.status <= ST_RANGE;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_GET: begin
          first <= 1'b1;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (first) begin
            got   <= ram_rdata;
            first <= 1'b0;
          end
          if (rem != '0) begin
            j     <= dir_up ? j - ADDR_W'(1) : j + ADDR_W'(1);
            waddr <= dir_up ? j + ADDR_W'(1) : j - ADDR_W'(1);
            rem   <= rem - LEN_W'(1);
            pend  <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (rem == '0 && !pend && !first) begin
            if (dir_up) begin
              state <= S_PUT;
            end else begin
              length     <= length - LEN_W'(1);
              res.value  <= got;
              res.status <= ST_OK;
              res.last   <= 1'b1;
              state      <= S_EMIT;
            end
          end
        end
        S_PUT: begin
          length     <= length + LEN_W'(1);
          res.value  <= '0;
          res.status <= ST_OK;
          res.last   <= 1'b1;
          state      <= S_EMIT;
        end
        S_RD_ISSUE: begin
          j     <= j + ADDR_W'(1);
          rem   <= rem - LEN_W'(1);
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (out_free) begin
            if (rem != '0) begin
              j   <= j + ADDR_W'(1);
              rem <= rem - LEN_W'(1);
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The list never grows beyond its capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(CAPACITY))
    else $error("list length above capacity");

  // A shift never reads the entry it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write of one entry in one cycle");

  // Placing the new value grows the list by one
  a_put_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |=> (length == $past(length) + LEN_W'(1)))
    else $error("insert did not grow the list");

  // An unused command goes straight to a single result
  a_bad_cmd: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == CMD_SPARE) |=> (state == S_EMIT && res.status == ST_RANGE))
    else $error("unused command not flagged");

  // A result is loaded only when the output register has room
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result beat overwritten");

endmodule
